[rtl/core/whisker_baseline_calibrator_core_defines.svh]
// ---------------------------------------------------------------------------
// Whisker baseline calibrator assertion macros
// Shared shorthand for the concurrent checks on the calibrator core.
// ---------------------------------------------------------------------------
`ifndef WHISKER_BASELINE_CALIBRATOR_CORE_DEFINES_SVH
`define WHISKER_BASELINE_CALIBRATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WBC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/wbc_pkg.sv]
// ---------------------------------------------------------------------------
// Whisker baseline calibrator package
// Widths, reset values and types shared by the calibrator modules.
// ---------------------------------------------------------------------------
package wbc_pkg;

   // Window geometry: the calibration mean divides by the window length,
   // so the length is fixed to a power of two.
   localparam int WINDOW_LEN = 8;
   localparam int WIN_LOG2   = 3;
   localparam int FILL_W     = 4;

   // Field and state widths.
   localparam int ENTRY_W = 12;
   localparam int BASE_W  = 12;
   localparam int SUM_W   = 16;
   localparam int CFG_W   = 10;
   localparam int DEFL_W  = 11;

   // Reset values and limits.
   localparam int BASE_RESET = 1000;
   localparam int REST_RESET = 50;
   localparam int BASE_MAX   = 4095;
   localparam int DEFL_MAX   = 2047;
   localparam int OFF_MIN    = -2048;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic        [BASE_W-1:0]  base_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic        [CFG_W-1:0]   cfg_type;
   typedef logic        [DEFL_W-1:0]  defl_type;
   typedef logic        [FILL_W-1:0]  fill_type;

   // Per-beat control handed from the top level to each channel.
   typedef struct packed {
      logic    step;
      logic    restart;
      cfg_type resting_point;
   } chan_ctl_type;

endpackage

[rtl/core/wbc_ifs.sv]
// ---------------------------------------------------------------------------
// Whisker baseline calibrator channel interfaces
// Valid/ready channels for sample beats, deflection beats and the CSR write.
// ---------------------------------------------------------------------------
interface wbc_req_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_right;
   logic [SAMPLE_BITS-1:0] sample_left;
   logic                   restart_calibration;

   modport source (output valid, sample_right, sample_left, restart_calibration,
                   input ready);
   modport sink   (input valid, sample_right, sample_left, restart_calibration,
                   output ready);
endinterface

interface wbc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [wbc_pkg::DEFL_W-1:0] deflection_right;
   logic [wbc_pkg::DEFL_W-1:0] deflection_left;

   modport source (output valid, deflection_right, deflection_left, input ready);
   modport sink   (input valid, deflection_right, deflection_left, output ready);
endinterface

interface wbc_csr_if;
   logic                      valid;
   logic                      ready;
   logic [wbc_pkg::CFG_W-1:0] resting_point;

   modport source (output valid, resting_point, input ready);
   modport sink   (input valid, resting_point, output ready);
endinterface

[rtl/core/whisker_baseline_calibrator_core.sv]
// ---------------------------------------------------------------------------
// Whisker baseline calibrator core
// Two whisker channels with self-calibrating baselines and clamped deflection.
// ---------------------------------------------------------------------------
// A result beat is presented in the cycle after its sample beat is accepted.
// One beat per cycle unless stalled; each channel's baseline update closes within
// the cycle of its beat, so the next beat sees the updated baseline.
// A waiting result does not block a new beat when the sink takes it that cycle.
// Reset: synchronous; baselines return to 1000, done marks and window fills
// clear, resting point returns to 50, and the result register empties.
module whisker_baseline_calibrator_core #(
   parameter int SAMPLE_BITS = 10
) (
   input logic clock,
   input logic reset,
   wbc_req_if.sink   req_chan,
   wbc_rsp_if.source rsp_chan,
   wbc_csr_if.sink   csr_chan
);
   import wbc_pkg::*;

   cfg_type      rest_ff, rest_in;
   logic         rsp_valid_ff, rsp_valid_in;
   defl_type     defl_right_ff, defl_right_in;
   defl_type     defl_left_ff, defl_left_in;
   logic         step;
   chan_ctl_type ctl;
   defl_type     defl_right, defl_left;

   // Configuration writes are always taken.
   assign csr_chan.ready = 1'b1;
   assign rest_in = csr_chan.valid ? csr_chan.resting_point : rest_ff;

   // A new beat enters when the result register is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign step           = req_chan.valid && req_chan.ready;

   always_comb begin
      ctl.step          = step;
      ctl.restart       = req_chan.restart_calibration;
      ctl.resting_point = rest_ff;
   end

   // Right and left channels.
   wbc_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_chan_right (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sample     (req_chan.sample_right),
      .deflection (defl_right)
   );

   wbc_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_chan_left (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sample     (req_chan.sample_left),
      .deflection (defl_left)
   );

   // Result register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      defl_right_in = defl_right_ff;
      defl_left_in  = defl_left_ff;
      if (step) begin
         rsp_valid_in  = 1'b1;
         defl_right_in = defl_right;
         defl_left_in  = defl_left;
      end else if (rsp_chan.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff      <= cfg_type'(REST_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         rest_ff      <= rest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      defl_right_ff <= defl_right_in;
      defl_left_ff  <= defl_left_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.deflection_right = defl_right_ff;
   assign rsp_chan.deflection_left  = defl_left_ff;

endmodule

[rtl/core/wbc_cell.sv]
// ---------------------------------------------------------------------------
// Whisker baseline calibrator window cell
// One entry of the offset window; on a push it takes its neighbor's entry.
// ---------------------------------------------------------------------------
module wbc_cell (
   input  logic               clock,
   input  logic               shift,
   input  wbc_pkg::entry_type din,
   output wbc_pkg::entry_type dout
);
   import wbc_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Hold the entry unless the window is pushed.
   always_comb begin
      entry_in = shift ? din : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign dout = entry_ff;

endmodule

[rtl/core/wbc_chan.sv]
// ---------------------------------------------------------------------------
// Whisker baseline calibrator channel
// Baseline, done mark, running window sum and a row of window cells for one
// whisker; produces the clamped deflection of the current sample.
// ---------------------------------------------------------------------------
module wbc_chan #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wbc_pkg::chan_ctl_type ctl,
   input  logic [SAMPLE_BITS-1:0] sample,
   output wbc_pkg::defl_type     deflection
);
   import wbc_pkg::*;

   localparam int DW = ((SAMPLE_BITS > BASE_W) ? SAMPLE_BITS : BASE_W) + 1;
   localparam logic signed [DW-1:0] OFF_MIN_D  = DW'(OFF_MIN);
   localparam logic signed [DW-1:0] DEFL_MAX_D = DW'(DEFL_MAX);

   base_type  baseline_ff, baseline_in;
   logic      done_ff, done_in;
   fill_type  fill_ff, fill_in;
   sum_type   sum_ff, sum_in;

   base_type  base_eff;
   logic      done_eff;
   logic signed [DW-1:0] diff;
   logic      push;
   entry_type off;
   entry_type cell_q [WINDOW_LEN];
   logic      full;
   sum_type   sum_upd;
   fill_type  fill_upd;
   logic signed [SUM_W:0]   lim_chk;
   logic      too_low;
   logic signed [18:0]      sum_x19;
   logic signed [18:0]      num1;
   logic        [12:0]      q1;
   base_type  base_shrink;
   logic        [BASE_W:0]  base_plus_rest;
   logic signed [17:0]      num2;
   logic        [13:0]      q2;
   base_type  base_settle;

   // Restart takes effect before this beat's sample is processed.
   always_comb begin
      base_eff = ctl.restart ? base_type'(BASE_RESET) : baseline_ff;
      done_eff = ctl.restart ? 1'b0 : done_ff;
   end

   // Offset of the sample against the baseline.
   always_comb begin
      diff = $signed({{(DW-SAMPLE_BITS){1'b0}}, sample})
           - $signed({{(DW-BASE_W){1'b0}}, base_eff});
      push = ctl.step && diff[DW-1] && !done_eff;
      off  = (diff < OFF_MIN_D) ? entry_type'(OFF_MIN) : diff[ENTRY_W-1:0];
   end

   // Deflection: negative offsets read as zero, large ones saturate.
   always_comb begin
      if (diff[DW-1]) begin
         deflection = '0;
      end else if (diff > DEFL_MAX_D) begin
         deflection = defl_type'(DEFL_MAX);
      end else begin
         deflection = diff[DEFL_W-1:0];
      end
   end

   // Row of window cells; the last cell holds the oldest entry.
   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      wbc_cell u_cell (
         .clock (clock),
         .shift (push),
         .din   ((i == 0) ? off : cell_q[(i == 0) ? 0 : i-1]),
         .dout  (cell_q[i])
      );
   end

   // Running sum after this push, dropping the oldest entry when full.
   always_comb begin
      full     = (fill_ff == fill_type'(WINDOW_LEN));
      sum_upd  = sum_ff - (full ? sum_type'(cell_q[WINDOW_LEN-1]) : '0) + sum_type'(off);
      fill_upd = full ? fill_ff : fill_ff + fill_type'(1);
   end

   // Mean test: sum below minus resting point times the window length.
   always_comb begin
      lim_chk = $signed({sum_upd[SUM_W-1], sum_upd})
              + $signed({{(SUM_W+1-CFG_W-WIN_LOG2){1'b0}}, ctl.resting_point,
                         {WIN_LOG2{1'b0}}});
      too_low = lim_chk[SUM_W];
   end

   // Shrink update: (4N*baseline + 3*sum) / 4N, a negative quotient saturates to zero.
   always_comb begin
      sum_x19 = 19'(sum_upd);
      num1    = $signed({2'b00, base_eff, 5'b00000}) + sum_x19 + (sum_x19 <<< 1);
      q1      = num1[17:5];
      if (num1[18]) begin
         base_shrink = '0;
      end else if (q1 > 13'(BASE_MAX)) begin
         base_shrink = base_type'(BASE_MAX);
      end else begin
         base_shrink = q1[BASE_W-1:0];
      end
   end

   // Settle update: (N*(baseline + resting point) + sum) / N.
   always_comb begin
      base_plus_rest = {1'b0, base_eff} + {{(BASE_W+1-CFG_W){1'b0}}, ctl.resting_point};
      num2 = $signed({2'b00, base_plus_rest, {WIN_LOG2{1'b0}}}) + 18'(sum_upd);
      q2   = num2[16:3];
      if (num2[17]) begin
         base_settle = '0;
      end else if (q2 > 14'(BASE_MAX)) begin
         base_settle = base_type'(BASE_MAX);
      end else begin
         base_settle = q2[BASE_W-1:0];
      end
   end

   // Next state of the channel.
   always_comb begin
      baseline_in = baseline_ff;
      done_in     = done_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      if (ctl.step) begin
         baseline_in = base_eff;
         done_in     = done_eff;
      end
      if (push) begin
         fill_in = fill_upd;
         sum_in  = sum_upd;
         if (fill_upd == fill_type'(WINDOW_LEN)) begin
            if (too_low) begin
               baseline_in = base_shrink;
               fill_in     = '0;
               sum_in      = '0;
            end else begin
               baseline_in = base_settle;
               done_in     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff <= base_type'(BASE_RESET);
         done_ff     <= 1'b0;
         fill_ff     <= '0;
         sum_ff      <= '0;
      end else begin
         baseline_ff <= baseline_in;
         done_ff     <= done_in;
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

[rtl/core/wbc_checker.sv]
// ---------------------------------------------------------------------------
// Whisker baseline calibrator checker
// Port-level checks on the calibrator core, attached by a bind statement.
// ---------------------------------------------------------------------------
`include "whisker_baseline_calibrator_core_defines.svh"

module wbc_checker #(
   parameter int SAMPLE_BITS = 10
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [SAMPLE_BITS-1:0]     sample_right,
   input logic                       restart_calibration,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [wbc_pkg::DEFL_W-1:0] deflection_right,
   input logic [wbc_pkg::DEFL_W-1:0] deflection_left
);
   import wbc_pkg::*;

   // A stalled result beat keeps its payload.
   `WBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(deflection_right) && $stable(deflection_left), "stalled result beat changed")

   // Every accepted sample beat yields a result beat in the next cycle.
   `WBC_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid, "accepted beat gave no result")

   // An empty result register never holds off a sample beat.
   `WBC_ASSERT_NOW(a_ready_empty, clock, reset, !rsp_valid, req_ready, "input stalled with empty output")

   // After a restart the baseline is 1000, so a zero sample deflects by zero.
   `WBC_ASSERT_NEXT(a_restart_zero, clock, reset, req_valid && req_ready && restart_calibration && (sample_right == '0), deflection_right == '0, "restart baseline not applied")

endmodule

bind whisker_baseline_calibrator_core wbc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wbc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .sample_right        (req_chan.sample_right),
   .restart_calibration (req_chan.restart_calibration),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .deflection_right    (rsp_chan.deflection_right),
   .deflection_left     (rsp_chan.deflection_left)
);
